/* rtl/wpsc_pkg.sv */
// shared types, constants and codes for the wipe position sweep controller
`timescale 1ns / 1ps

package wpsc_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int SPEED_SHIFT   = 8;
	localparam int SPEED_W       = 16;
	localparam int DELTA_W       = 16;
	localparam int POS_W         = FRACTION_BITS + 1;
	localparam int PROD_W        = SPEED_W + DELTA_W;
	localparam int STEP_W        = PROD_W - SPEED_SHIFT;
	localparam int SUM_W         = ((STEP_W > POS_W) ? STEP_W : POS_W) + 1;
	localparam int CFG_IDX_W     = 1;

	localparam logic [POS_W-1:0]   POS_ONE     = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [POS_W-1:0]   POS_HALF    = POS_ONE >> 1;
	localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(256);

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_TOGGLE = 3'd3,
		CMD_SET   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_L2R  = 2'd0,
		MODE_R2L  = 2'd1,
		MODE_PING = 2'd2
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_SPEED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_SPEED   = 1'b1;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [1:0]         start_mode;
		logic [DELTA_W-1:0] delta;
		logic               jog_left;
		logic               jog_right;
		logic [POS_W-1:0]   new_position;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] position_out;
		logic             active;
		logic             returning;
		logic             rising;
		logic [1:0]       mode_out;
	} out_item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             auto_on;
		logic             to_centre;
		logic             going_up;
		logic [1:0]       run_mode;
	} sweep_state_t;

endpackage

/* rtl/wpsc_step.sv */
// next-state logic for one command item
`timescale 1ns / 1ps

module wpsc_step (
	input  wpsc_pkg::sweep_state_t      state,
	input  wpsc_pkg::in_item_t          item,
	input  logic [wpsc_pkg::STEP_W-1:0] step,
	output wpsc_pkg::sweep_state_t      next
);
	import wpsc_pkg::*;

	logic [POS_W-1:0] pos;
	logic [SUM_W-1:0] pos_x;
	logic [SUM_W-1:0] step_x;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] back;
	logic [SUM_W-1:0] fold_in;
	logic [POS_W-1:0] fold_r;
	logic [POS_W-1:0] fold_pos;
	logic             fold_up;
	logic [POS_W-1:0] centre_pos;
	logic [1:0]       start_sel;
	logic             do_start;
	logic             do_stop;

	assign pos    = (state.position > POS_ONE) ? POS_ONE : state.position;
	assign pos_x  = SUM_W'(pos);
	assign step_x = SUM_W'(step);
	assign sum    = pos_x + step_x;
	// overshoot below zero, only meaningful when step exceeds position
	assign back   = step_x - pos_x;

	// modulo 2.0 is a mask; 2.0 - r is the two's complement in POS_W bits
	assign fold_in = state.going_up ? sum : back;
	assign fold_r  = fold_in[POS_W-1:0];
	always_comb begin
		if (fold_r == '0) begin
			fold_pos = '0;
			fold_up  = 1'b0;
		end else if (fold_r <= POS_ONE) begin
			fold_pos = fold_r;
			fold_up  = 1'b1;
		end else begin
			fold_pos = POS_W'(0) - fold_r;
			fold_up  = 1'b0;
		end
	end

	always_comb begin
		if (pos < POS_HALF) begin
			centre_pos = (sum > SUM_W'(POS_HALF)) ? POS_HALF : sum[POS_W-1:0];
		end else begin
			centre_pos = (SUM_W'(pos - POS_HALF) <= step_x) ? POS_HALF
				: POS_W'(pos_x - step_x);
		end
	end

	always_comb begin
		next          = state;
		next.position = pos;
		do_start      = 1'b0;
		do_stop       = 1'b0;
		start_sel     = item.start_mode;
		case (item.cmd)
			CMD_TICK: begin
				if (item.jog_left || item.jog_right) begin
					next.auto_on   = 1'b0;
					next.to_centre = 1'b0;
					if (item.jog_right && !item.jog_left) begin
						next.position = (sum > SUM_W'(POS_ONE)) ? POS_ONE : sum[POS_W-1:0];
					end else if (item.jog_left && !item.jog_right) begin
						next.position = (step_x >= pos_x) ? '0 : POS_W'(pos_x - step_x);
					end
				end else if (state.auto_on) begin
					if (state.to_centre) begin
						next.position = centre_pos;
						if (centre_pos == POS_HALF) begin
							next.auto_on   = 1'b0;
							next.to_centre = 1'b0;
						end
					end else begin
						case (state.run_mode)
							MODE_L2R: begin
								if (sum >= SUM_W'(POS_ONE)) begin
									next.position = POS_ONE;
									next.auto_on  = 1'b0;
								end else begin
									next.position = sum[POS_W-1:0];
								end
							end
							MODE_R2L: begin
								if (step_x >= pos_x) begin
									next.position = '0;
									next.auto_on  = 1'b0;
								end else begin
									next.position = POS_W'(pos_x - step_x);
								end
							end
							MODE_PING: begin
								if (state.going_up) begin
									if (sum <= SUM_W'(POS_ONE)) begin
										next.position = sum[POS_W-1:0];
									end else begin
										next.position = fold_pos;
										next.going_up = fold_up;
									end
								end else if (step_x <= pos_x) begin
									next.position = POS_W'(pos_x - step_x);
								end else if (back <= SUM_W'(POS_ONE)) begin
									next.position = back[POS_W-1:0];
									next.going_up = 1'b1;
								end else begin
									next.position = fold_pos;
									next.going_up = fold_up;
								end
							end
							default: begin
								next.position = pos;
							end
						endcase
					end
				end
			end
			CMD_START: begin
				do_start = 1'b1;
			end
			CMD_STOP: begin
				do_stop = 1'b1;
			end
			CMD_TOGGLE: begin
				do_stop   = state.auto_on;
				do_start  = !state.auto_on;
				start_sel = state.run_mode;
			end
			CMD_SET: begin
				next.position = (item.new_position > POS_ONE) ? POS_ONE : item.new_position;
			end
			default: begin
				next.position = pos;
			end
		endcase

		if (do_start) begin
			next.auto_on   = 1'b1;
			next.going_up  = 1'b1;
			next.to_centre = 1'b0;
			case (start_sel)
				MODE_R2L: begin
					next.run_mode = MODE_R2L;
					next.position = POS_ONE;
				end
				MODE_PING: begin
					next.run_mode = MODE_PING;
					next.position = POS_HALF;
				end
				default: begin
					// unused mode code falls back to left-to-right
					next.run_mode = MODE_L2R;
					next.position = '0;
				end
			endcase
		end

		if (do_stop) begin
			if (state.run_mode == MODE_PING && state.auto_on && pos != POS_HALF) begin
				next.to_centre = 1'b1;
			end else begin
				next.auto_on   = 1'b0;
				next.to_centre = 1'b0;
				next.position  = POS_HALF;
			end
		end
	end

endmodule

/* rtl/wipe_position_sweep_controller.sv */
// top level: input stage with step multiply, state update and result register
// an accepted item is held in the input register, its result then in the result register
// throughput: one item per cycle unless the output is stalled; the step product is formed
// ahead of the input register, the state update feeds the result register on advance
// reset: position at centre, auto motion off, direction rising, left-to-right mode,
// both speeds 256, pipeline empty
`timescale 1ns / 1ps

module wipe_position_sweep_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  wpsc_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output wpsc_pkg::out_item_t            out_item,
	input  logic                           cfg_we,
	input  logic [wpsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wpsc_pkg::SPEED_W-1:0]   cfg_wdata
);
	import wpsc_pkg::*;

	logic [SPEED_W-1:0] manual_speed_q;
	logic [SPEED_W-1:0] auto_speed_q;
	logic [SPEED_W-1:0] speed_sel;
	logic [PROD_W-1:0]  prod;

	logic               valid_s1;
	in_item_t           item_s1;
	logic [STEP_W-1:0]  step_s1;

	sweep_state_t       state_q;
	sweep_state_t       state_next;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic               accept;
	logic               advance;

	// manual request picks the manual rate, otherwise the auto rate
	assign speed_sel = (in_item.jog_left || in_item.jog_right) ? manual_speed_q : auto_speed_q;
	assign prod      = PROD_W'(speed_sel) * PROD_W'(in_item.delta);

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_speed_q <= SPEED_RESET;
			auto_speed_q   <= SPEED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MANUAL_SPEED: manual_speed_q <= cfg_wdata;
				REG_AUTO_SPEED:   auto_speed_q   <= cfg_wdata;
				default: begin
					manual_speed_q <= manual_speed_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			step_s1 <= prod[PROD_W-1:SPEED_SHIFT];
		end
	end

	wpsc_step u_step (
		.state (state_q),
		.item  (item_s1),
		.step  (step_s1),
		.next  (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.position  <= POS_HALF;
			state_q.auto_on   <= 1'b0;
			state_q.to_centre <= 1'b0;
			state_q.going_up  <= 1'b1;
			state_q.run_mode  <= MODE_L2R;
			out_valid_q       <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.position_out <= state_next.position;
			out_item_q.active       <= state_next.auto_on;
			out_item_q.returning    <= state_next.to_centre;
			out_item_q.rising       <= state_next.going_up;
			out_item_q.mode_out     <= state_next.run_mode;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

/* test/wipe_sweep_checker_pkg.sv */
// scoreboard class: predicts each result of the sweep controller and checks what comes out
`timescale 1ns / 1ps

package wipe_sweep_checker_pkg;

	import wpsc_pkg::*;

	// wide enough for speed * delta and for any position plus step
	typedef logic [39:0] wide_t;

	localparam wide_t ONE_W  = wide_t'(POS_ONE);
	localparam wide_t HALF_W = wide_t'(POS_HALF);
	localparam wide_t TWO_W  = ONE_W << 1;

	class wipe_sweep_checker;
		logic [POS_W-1:0]   position;
		logic               auto_on;
		logic               to_center;
		logic               going_up;
		mode_t              sweep;
		logic [SPEED_W-1:0] manual_rate;
		logic [SPEED_W-1:0] auto_rate;
		out_item_t          expected_sweeps[$];
		int unsigned        errors;
		int unsigned        checked;

		function new();
			position    = POS_HALF;
			auto_on     = 1'b0;
			to_center   = 1'b0;
			going_up    = 1'b1;
			sweep       = MODE_L2R;
			manual_rate = SPEED_RESET;
			auto_rate   = SPEED_RESET;
			errors      = 0;
			checked     = 0;
		endfunction

		function void write_rate(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] rate);
			if (idx == REG_MANUAL_SPEED)
				manual_rate = rate;
			else if (idx == REG_AUTO_SPEED)
				auto_rate = rate;
		endfunction

		function int unsigned pending();
			return expected_sweeps.size();
		endfunction

		function wide_t step_of(input logic [SPEED_W-1:0] rate, input logic [DELTA_W-1:0] span);
			return (wide_t'(rate) * wide_t'(span)) >> SPEED_SHIFT;
		endfunction

		// fold an upward target past one back into range, modulo two
		function wide_t fold_back(input wide_t target);
			wide_t r;
			r = target % TWO_W;
			if (r == '0) begin
				going_up = 1'b0;
				return '0;
			end
			if (r <= ONE_W) begin
				going_up = 1'b1;
				return r;
			end
			going_up = 1'b0;
			return TWO_W - r;
		endfunction

		function void start_sweep(input logic [1:0] requested);
			sweep     = (requested == MODE_R2L || requested == MODE_PING) ? mode_t'(requested) : MODE_L2R;
			auto_on   = 1'b1;
			going_up  = 1'b1;
			to_center = 1'b0;
			case (sweep)
				MODE_R2L:  position = POS_ONE;
				MODE_PING: position = POS_HALF;
				default:   position = '0;
			endcase
		endfunction

		function void stop_sweep();
			// ping-pong off center glides home first
			if (sweep == MODE_PING && auto_on && position != POS_HALF) begin
				to_center = 1'b1;
			end else begin
				auto_on   = 1'b0;
				to_center = 1'b0;
				position  = POS_HALF;
			end
		endfunction

		function void tick(input logic [DELTA_W-1:0] span, input logic go_left, input logic go_right);
			wide_t p;
			wide_t s;
			p = wide_t'(position);
			if (go_left || go_right) begin
				auto_on   = 1'b0;
				to_center = 1'b0;
				s = step_of(manual_rate, span);
				if (go_right && !go_left)
					p = (p + s > ONE_W) ? ONE_W : p + s;
				else if (go_left && !go_right)
					p = (s >= p) ? '0 : p - s;
			end else if (auto_on) begin
				s = step_of(auto_rate, span);
				if (to_center) begin
					if (p < HALF_W)
						p = (p + s > HALF_W) ? HALF_W : p + s;
					else
						p = (p - HALF_W <= s) ? HALF_W : p - s;
					if (p == HALF_W) begin
						auto_on   = 1'b0;
						to_center = 1'b0;
					end
				end else begin
					case (sweep)
						MODE_L2R: begin
							p = (p + s >= ONE_W) ? ONE_W : p + s;
							if (p >= ONE_W)
								auto_on = 1'b0;
						end
						MODE_R2L: begin
							p = (s >= p) ? '0 : p - s;
							if (p == '0)
								auto_on = 1'b0;
						end
						MODE_PING: begin
							if (going_up) begin
								p = (p + s <= ONE_W) ? p + s : fold_back(p + s);
							end else if (s <= p) begin
								p = p - s;
							end else begin
								// bounced off zero, remaining travel goes up
								going_up = 1'b1;
								p = (s - p <= ONE_W) ? s - p : fold_back(s - p);
							end
						end
						default: ;
					endcase
				end
			end
			position = POS_W'(p);
		endfunction

		function void predict_sweep(input in_item_t it);
			if (position > POS_ONE)
				position = POS_ONE;
			case (it.cmd)
				CMD_TICK:   tick(it.delta, it.jog_left, it.jog_right);
				CMD_START:  start_sweep(it.start_mode);
				CMD_STOP:   stop_sweep();
				CMD_TOGGLE: begin
					if (auto_on)
						stop_sweep();
					else
						start_sweep(sweep);
				end
				CMD_SET:    position = (it.new_position > POS_ONE) ? POS_ONE : it.new_position;
				default: ;
			endcase
			expected_sweeps.push_back('{position_out: position, active: auto_on,
				returning: to_center, rising: going_up, mode_out: sweep});
		endfunction

		function void check_sweep(input out_item_t got);
			out_item_t want;
			if (expected_sweeps.size() == 0) begin
				$error("result with no item pending: position_out=%0d", got.position_out);
				errors++;
				return;
			end
			want = expected_sweeps.pop_front();
			checked++;
			if (got.position_out !== want.position_out) begin
				$error("position_out: expected %0d, actual %0d", want.position_out, got.position_out);
				errors++;
			end
			if (got.active !== want.active) begin
				$error("active: expected %0b, actual %0b", want.active, got.active);
				errors++;
			end
			if (got.returning !== want.returning) begin
				$error("returning: expected %0b, actual %0b", want.returning, got.returning);
				errors++;
			end
			if (got.rising !== want.rising) begin
				$error("rising: expected %0b, actual %0b", want.rising, got.rising);
				errors++;
			end
			if (got.mode_out !== want.mode_out) begin
				$error("mode_out: expected %0d, actual %0d", want.mode_out, got.mode_out);
				errors++;
			end
		endfunction
	endclass

endpackage

/* test/wipe_position_sweep_controller_test.sv */
// top-level testbench: drives commands and speed writes, checks every result of the controller
`timescale 1ns / 1ps

module wipe_position_sweep_controller_test;

	import wpsc_pkg::*;
	import wipe_sweep_checker_pkg::*;

	localparam int          PIPE_DEPTH      = 2;
	localparam int          N_PHASES        = 7;
	localparam int          ITEMS_PER_PHASE = 150;
	localparam int          HOLD_CYCLES     = 200;
	localparam int          CYCLE_LIMIT     = 100000;
	localparam logic [2:0]  CMD_SPARE_LO    = 3'd5;
	localparam logic [2:0]  CMD_SPARE_HI    = 3'd7;
	localparam logic [1:0]  MODE_SPARE      = 2'd3;

	localparam logic [SPEED_W-1:0] MANUAL_RATES [N_PHASES] =
		'{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'd4096, 16'd0, 16'd40};
	localparam logic [SPEED_W-1:0] AUTO_RATES [N_PHASES] =
		'{16'd256, 16'hFFFF, 16'd0, 16'd3000, 16'd700, 16'd0, 16'hFFFF};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SPEED_W-1:0]   cfg_wdata;

	logic        hold_off_req = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned stalled_cycles = 0;

	wipe_sweep_checker sweeps = new();

	wipe_position_sweep_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles", CYCLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sweeps.check_sweep(out_item);
		if (in_valid && in_stall)
			stalled_cycles <= stalled_cycles + 1;
	end

	// receiver: segments of free flow, random, alternating and heavy stalling
	initial begin : receiver
		int unsigned style;
		int unsigned seg;
		out_stall <= 1'b0;
		forever begin
			style = $urandom_range(0, 3);
			seg   = $urandom_range(1, 40);
			for (int k = 0; k < seg; k++) begin
				@(posedge clk);
				if (hold_off_req) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					out_stall    <= 1'b0;
					hold_off_req <= 1'b0;
				end else begin
					case (style)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 99) < 30);
						2: out_stall <= k[0];
						default: out_stall <= ($urandom_range(0, 99) < 75);
					endcase
				end
			end
		end
	end

	function automatic in_item_t make_item(input logic [2:0] code, input logic [1:0] sweep_sel,
		input logic [DELTA_W-1:0] span, input logic go_left, input logic go_right,
		input logic [POS_W-1:0] spot);
		in_item_t it;
		it.cmd          = code;
		it.start_mode   = sweep_sel;
		it.delta        = span;
		it.jog_left     = go_left;
		it.jog_right    = go_right;
		it.new_position = spot;
		return it;
	endfunction

	function automatic in_item_t random_command();
		in_item_t    it;
		int unsigned pick;
		int unsigned tier;
		// fields that the command ignores still carry random bits
		it = make_item(CMD_TICK, 2'($urandom), 16'($urandom), 1'b0, 1'b0, 17'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			tier = $urandom_range(0, 99);
			if (tier < 15)
				it.delta = 16'($urandom_range(0, 15));
			else if (tier < 55)
				it.delta = 16'($urandom_range(0, 4095));
			else if (tier < 85)
				it.delta = 16'($urandom_range(0, 32767));
			if ($urandom_range(0, 99) < 20) begin
				case ($urandom_range(0, 2))
					0: it.jog_left = 1'b1;
					1: it.jog_right = 1'b1;
					default: begin
						it.jog_left  = 1'b1;
						it.jog_right = 1'b1;
					end
				endcase
			end
		end else if (pick < 76) begin
			it.cmd = CMD_START;
		end else if (pick < 81) begin
			it.cmd = CMD_STOP;
		end else if (pick < 87) begin
			it.cmd = CMD_TOGGLE;
		end else if (pick < 95) begin
			it.cmd = CMD_SET;
			tier = $urandom_range(0, 99);
			if (tier < 70)
				it.new_position = POS_W'($urandom_range(0, 65536));
			else if (tier < 85)
				it.new_position = ($urandom_range(0, 1) != 0) ? POS_ONE : '0;
		end else begin
			it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sweeps.predict_sweep(it);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sweeps.pending() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic set_speeds(input logic [SPEED_W-1:0] manual, input logic [SPEED_W-1:0] sweep_rate);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MANUAL_SPEED;
		cfg_wdata <= manual;
		@(posedge clk);
		sweeps.write_rate(REG_MANUAL_SPEED, manual);
		cfg_index <= REG_AUTO_SPEED;
		cfg_wdata <= sweep_rate;
		@(posedge clk);
		sweeps.write_rate(REG_AUTO_SPEED, sweep_rate);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		bit          paused;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MANUAL_SPEED;
		cfg_wdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick and spare command codes change nothing
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_SPARE_LO, MODE_PING, 16'd1, 1'b1, 1'b1, POS_HALF));
		send_item(make_item(CMD_SPARE_HI, MODE_SPARE, 16'd0, 1'b0, 1'b1, '1));
		// set position saturates above one
		send_item(make_item(CMD_SET, MODE_L2R, 16'd0, 1'b0, 1'b0, '1));
		send_item(make_item(CMD_SET, MODE_L2R, 16'd0, 1'b0, 1'b0, '0));
		// spare start mode runs left to right up to the end
		send_item(make_item(CMD_START, MODE_SPARE, 16'd0, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'd1, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_START, MODE_R2L, 16'd0, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'd1, 1'b0, 1'b0, '0));
		// ping-pong: land exactly on one, bounce down, bounce off zero
		send_item(make_item(CMD_START, MODE_PING, 16'd0, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'd32768, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'd10, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b0, 1'b0, '0));
		// stop off center returns home, then toggle on and off at center
		send_item(make_item(CMD_STOP, MODE_L2R, 16'd0, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TOGGLE, MODE_L2R, 16'd0, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TOGGLE, MODE_L2R, 16'd0, 1'b0, 1'b0, '0));
		// manual moves with clamping at both ends
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b0, 1'b1, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b1, 1'b1, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b1, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b1, 1'b0, '0));
		send_item(make_item(CMD_STOP, MODE_L2R, 16'd0, 1'b0, 1'b0, '0));
		// fold landing on a multiple of two, then a fold from below zero
		settle();
		set_speeds(16'd256, 16'd512);
		send_item(make_item(CMD_START, MODE_PING, 16'd0, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_SET, MODE_L2R, 16'd0, 1'b0, 1'b0, POS_W'(2)));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b0, 1'b0, '0));
		send_item(make_item(CMD_TICK, MODE_L2R, 16'hFFFF, 1'b0, 1'b0, '0));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			if (ph == 5)
				set_speeds(16'($urandom), 16'($urandom));
			else
				set_speeds(MANUAL_RATES[ph], AUTO_RATES[ph]);
			// long receiver hold-off while the sender keeps pushing
			if (ph == 1)
				hold_off_req <= 1'b1;
			sent   = 0;
			paused = 1'b0;
			while (sent < ITEMS_PER_PHASE) begin
				burst = (ph == 1 && sent == 0) ? 100 : $urandom_range(1, 30);
				for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
					send_item(random_command());
					sent++;
				end
				if (ph == 3 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
					settle();
					paused = 1'b1;
				end else begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
		end
		settle();

		$display("sent %0d commands over %0d speed settings, %0d results compared",
			items_sent, N_PHASES + 2, sweeps.checked);
		$display("input held back on %0d cycles while results were stalled", stalled_cycles);
		if (sweeps.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
